// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the sorted table search RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked assertion that is switched off while reset is applied.
`define STBS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define STBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define STBS_ASSERT(lbl, clk, rst_n, prop, msg)
`define STBS_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/stbs_pkg.sv -----
// Package for the sorted table search unit: item codes, sequencer states
// and the status struct of the search engine. No dependencies.
package stbs_pkg;

    // Width of one table element and of a search key.
    localparam int DATA_W = 32;

    // Codes of the kind field.
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // States of the search sequencer.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE
    } eng_state_t;

    // Status the engine reports to the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } eng_status_t;

endpackage

// ----- rtl/stbs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/stbs_engine.sv -----
// Binary search sequencer with its shared compare unit and bound registers.
// Depends on stbs_pkg and assert_macros.svh; reads the table through stbs_ram.
`include "assert_macros.svh"

module stbs_engine #(
    parameter int TABLE_DEPTH = 1024,
    localparam int POS_W  = $clog2(TABLE_DEPTH + 1),
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            launch,
    input  logic signed [stbs_pkg::DATA_W-1:0] key,
    input  logic [POS_W-1:0]                count,
    output logic                            rd_en,
    output logic [ADDR_W-1:0]               rd_addr,
    input  logic signed [stbs_pkg::DATA_W-1:0] rd_data,
    output logic [POS_W-1:0]                position,
    output stbs_pkg::eng_status_t           status
);

    import stbs_pkg::*;

    // Bounds carry one extra bit so that low can pass count.
    localparam int LH_W = POS_W + 1;

    eng_state_t state_reg, state_next;

    logic [LH_W-1:0]         low_reg, low_next;
    logic [LH_W-1:0]         high_reg, high_next;
    logic [LH_W-1:0]         mid_reg, mid_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic                    done_reg, done_next;

    logic [LH_W:0]   mid_sum;
    logic [LH_W-1:0] mid_calc;
    logic [LH_W-1:0] mid_m1;
    logic            range_open;
    logic            key_gt;
    logic            key_lt;

    // Midpoint of the current range and the range test.
    assign mid_sum    = {1'b0, low_reg} + {1'b0, high_reg};
    assign mid_calc   = mid_sum[LH_W:1];
    assign mid_m1     = mid_calc - LH_W'(1);
    assign range_open = (low_reg <= high_reg);

    // The shared compare unit: key against the element just read.
    assign key_gt = (key_reg > rd_data);
    assign key_lt = (key_reg < rd_data);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (launch)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                state_next = range_open ? ST_COMPARE : ST_IDLE;
            end
            ST_COMPARE:
            begin
                state_next = (key_gt || key_lt) ? ST_PROBE : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Bound, key and result updates.
    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        mid_next  = mid_reg;
        key_next  = key_reg;
        pos_next  = pos_reg;
        done_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (launch)
                begin
                    low_next  = LH_W'(1);
                    high_next = {1'b0, count};
                    key_next  = key;
                end
            end
            ST_PROBE:
            begin
                if (range_open)
                begin
                    mid_next = mid_calc;
                end
                else
                begin
                    pos_next  = '0;
                    done_next = 1'b1;
                end
            end
            ST_COMPARE:
            begin
                if (key_gt)
                begin
                    low_next = mid_reg + LH_W'(1);
                end
                else if (key_lt)
                begin
                    high_next = mid_reg - LH_W'(1);
                end
                else
                begin
                    pos_next  = mid_reg[POS_W-1:0];
                    done_next = 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Outputs toward the table and the top level.
    always_comb
    begin
        rd_en       = (state_reg == ST_PROBE) && range_open;
        rd_addr     = mid_m1[ADDR_W-1:0];
        status.busy = (state_reg != ST_IDLE);
        status.done = done_reg;
        position    = pos_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        low_reg  <= low_next;
        high_reg <= high_next;
        mid_reg  <= mid_next;
        key_reg  <= key_next;
        pos_reg  <= pos_next;
    end

    // A read is always followed by its compare.
    `STBS_ASSERT(a_read_then_compare, clk, rst_n, rd_en |=> (state_reg == ST_COMPARE), "read not followed by compare")
    // The probed midpoint lies inside a non-empty range.
    `STBS_ASSERT(a_mid_in_range, clk, rst_n, (state_reg == ST_COMPARE) |-> (low_reg <= mid_reg && mid_reg <= high_reg && mid_reg != '0), "midpoint outside range")
    // A result is only shown once the sequencer is back in idle.
    `STBS_ASSERT(a_done_idle, clk, rst_n, done_reg |-> (state_reg == ST_IDLE), "result while busy")
    // A found position can only come from a compare.
    `STBS_ASSERT(a_hit_from_compare, clk, rst_n, (done_reg && pos_reg != '0) |-> $past(state_reg == ST_COMPARE), "hit without compare")

endmodule

// ----- rtl/sorted_table_binary_search_unit.sv -----
// Top level of the sorted table search unit: element count, table RAM and
// search engine. Depends on stbs_pkg, stbs_ram, stbs_engine, assert_macros.svh.
//
// A beat is accepted on a rising edge with start high and busy low. An append
// (kind 0) keeps busy low; with start_new set the table is emptied first, and
// appends to a full table are dropped. A search (kind 1) runs its probes one
// after another, each a table read followed by one compare in the shared
// compare unit, for at most floor(log2(count)) + 1 probes, plus a last probe
// state that finds the range closed when there is no hit. The result beat
// follows in the cycle after the last busy cycle. It is on position for one
// cycle with done high, and busy is low in that cycle; the receiver cannot
// stall it, so it must take every result beat when it appears.
// The table needs no clearing after reset.
`include "assert_macros.svh"

module sorted_table_binary_search_unit #(
    parameter int TABLE_DEPTH = 1024,
    localparam int POS_W = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               kind,
    input  logic signed [stbs_pkg::DATA_W-1:0] value,
    input  logic                               start_new,
    output logic                               done,
    output logic [POS_W-1:0]                   position
);

    import stbs_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [POS_W-1:0] count_reg, count_next;
    logic [POS_W-1:0] base;
    logic             accept;
    logic             launch;
    logic             we;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic signed [DATA_W-1:0] rd_data;
    eng_status_t      status;

    assign accept = start && !status.busy;
    assign launch = accept && (kind == KIND_SEARCH);

    // Append path: pick the write slot and advance the count.
    always_comb
    begin
        base       = start_new ? '0 : count_reg;
        we         = 1'b0;
        count_next = count_reg;
        if (accept && (kind == KIND_APPEND))
        begin
            if (base < POS_W'(TABLE_DEPTH))
            begin
                we         = 1'b1;
                count_next = base + POS_W'(1);
            end
            else
            begin
                count_next = base;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Table storage; position p lives at address p - 1.
    stbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (base[ADDR_W-1:0]),
        .wdata (value),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Search sequencer.
    stbs_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .launch   (launch),
        .key      (value),
        .count    (count_reg),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .position (position),
        .status   (status)
    );

    assign busy = status.busy;
    assign done = status.done;

    // The count never passes the table depth.
    `STBS_ASSERT(a_count_bound, clk, rst_n, count_reg <= POS_W'(TABLE_DEPTH), "count beyond depth")
    // The table is not written while a search runs.
    `STBS_ASSERT(a_no_write_busy, clk, rst_n, we |-> !status.busy, "write during search")
    // A search launch always makes the engine busy next cycle.
    `STBS_ASSERT(a_launch_busy, clk, rst_n, launch |=> status.busy, "search not started")

endmodule

// ----- sim/sorted_table_binary_search_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the sorted table search unit: directed and random tables and searches.
// Depends on stbs_pkg and sorted_table_binary_search_unit; no files or arguments.
module sorted_table_binary_search_unit_tb;
    import stbs_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int POS_W = $clog2(TABLE_DEPTH + 1);
    localparam int RANDOM_BEATS = 650;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;

    // One command beat as the driver presents it.
    typedef struct {
        logic                      kind;
        logic signed [DATA_W-1:0]  value;
        logic                      start_new;
        int unsigned               idle_pct;
    } table_beat_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               kind;
    logic signed [DATA_W-1:0] value;
    logic               start_new;
    logic               done;
    logic [POS_W-1:0]   position;

    table_beat_t        pending_beats[$];
    logic [POS_W-1:0]   expected_positions[$];
    int                 error_count = 0;
    int                 cycle_count = 0;

    // Shadow of the table that the predictor keeps.
    logic signed [DATA_W-1:0] shadow_table[TABLE_DEPTH];
    int unsigned              shadow_count = 0;

    // Copy of the table as the stimulus generator builds it, used to pick keys.
    int                 gen_table[TABLE_DEPTH];
    int                 gen_count = 0;
    int                 random_total = 0;
    logic [POS_W-1:0]   got_want;

    sorted_table_binary_search_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .value     (value),
        .start_new (start_new),
        .done      (done),
        .position  (position)
    );

    // Clock and the single reset at the start of the run.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Binary search over the shadow table, probing midpoints until a hit or an empty range.
    function automatic logic [POS_W-1:0] search_position(input logic signed [DATA_W-1:0] key);
        int low;
        int high;
        int mid;
        low = 1;
        high = shadow_count;
        while (low <= high)
        begin
            mid = (low + high) / 2;
            if (key > shadow_table[mid - 1])
                low = mid + 1;
            else if (key < shadow_table[mid - 1])
                high = mid - 1;
            else
                return mid[POS_W-1:0];
        end
        return '0;
    endfunction

    // Update the shadow table for an accepted beat, or queue the expected position.
    task automatic apply_beat(input table_beat_t b);
        if (b.kind == KIND_APPEND)
        begin
            if (b.start_new)
                shadow_count = 0;
            if (shadow_count < TABLE_DEPTH)
            begin
                shadow_table[shadow_count] = b.value;
                shadow_count++;
            end
        end
        else
        begin
            expected_positions.push_back(search_position(b.value));
        end
    endtask

    // Driver: hold a beat until accepted, then present the next or idle.
    always @(posedge clk or negedge rst_n)
    begin : drive_beats
        logic took;
        if (!rst_n)
        begin
            start <= 1'b0;
            kind <= KIND_APPEND;
            value <= '0;
            start_new <= 1'b0;
        end
        else
        begin
            took = start && !busy;
            if (took)
                apply_beat(pending_beats.pop_front());
            if (start && !took)
            begin
                // Beat still waiting on a busy block: leave every input as it is.
            end
            else if (pending_beats.size() != 0 &&
                     $urandom_range(0, 99) >= pending_beats[0].idle_pct)
            begin
                start <= 1'b1;
                kind <= pending_beats[0].kind;
                value <= pending_beats[0].value;
                start_new <= pending_beats[0].start_new;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every result beat must match the oldest expected position.
    always @(posedge clk)
    begin
        if (rst_n && done !== 1'b0)
        begin
            if (expected_positions.size() == 0)
            begin
                error_count++;
                $display("%0t: result beat with none expected: expected nothing, got %0d",
                         $time, position);
            end
            else
            begin
                got_want = expected_positions.pop_front();
                if (position !== got_want)
                begin
                    error_count++;
                    $display("%0t: position mismatch: expected %0d, got %0d",
                             $time, got_want, position);
                end
            end
        end
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sorted_table_binary_search_unit_tb: done, errors");
            $finish;
        end
    end

    task automatic push_beat(input logic k, input int v, input logic sn, input int unsigned pct);
        table_beat_t b;
        b.kind = k;
        b.value = v;
        b.start_new = sn;
        b.idle_pct = pct;
        pending_beats.push_back(b);
        if (k == KIND_APPEND)
        begin
            if (sn)
                gen_count = 0;
            if (gen_count < TABLE_DEPTH)
            begin
                gen_table[gen_count] = v;
                gen_count++;
            end
        end
    endtask

    // Element values: full range, a narrow range rich in duplicates, or near the extremes.
    function automatic int pick_value(input int mode);
        int v;
        case (mode)
            0: v = $urandom;
            1: v = int'($urandom_range(0, 31)) - 16;
            default:
            begin
                if ($urandom_range(0, 1))
                    v = 32'sh8000_0000 + int'($urandom_range(0, 3));
                else
                    v = 32'sh7fff_ffff - int'($urandom_range(0, 3));
            end
        endcase
        return v;
    endfunction

    // Idle rate of the sender by phase of the random part.
    function automatic int unsigned phase_pct();
        case ((random_total / 100) % 3)
            0: return 0;
            1: return 50;
            default: return 10;
        endcase
    endfunction

    // A fresh table of n elements in ascending order, now and then with one stray element.
    task automatic build_table(input int n, input int mode, input int unsigned pct);
        int j;
        int k;
        int v;
        int sorted_vals[TABLE_DEPTH];
        for (j = 0; j < n; j++)
        begin
            v = pick_value(mode);
            k = j;
            while (k > 0 && sorted_vals[k - 1] > v)
            begin
                sorted_vals[k] = sorted_vals[k - 1];
                k--;
            end
            sorted_vals[k] = v;
        end
        if ($urandom_range(0, 9) == 0)
            sorted_vals[$urandom_range(0, n - 1)] = pick_value(0);
        for (j = 0; j < n; j++)
            push_beat(KIND_APPEND, sorted_vals[j], j == 0, pct);
    endtask

    // Searches whose keys mostly hit the table, with near misses and random keys.
    task automatic push_searches(input int m, input int mode, input int unsigned pct);
        int j;
        int key;
        int sel;
        for (j = 0; j < m; j++)
        begin
            sel = $urandom_range(0, 99);
            key = gen_table[$urandom_range(0, gen_count - 1)];
            if (sel >= 80)
                key = pick_value(sel >= 90 ? 0 : mode);
            else if (sel >= 65)
                key = key - 1;
            else if (sel >= 50)
                key = key + 1;
            push_beat(KIND_SEARCH, key, 1'($urandom_range(0, 1)), pct);
        end
    endtask

    // Stimulus and end of run.
    initial
    begin : stimulus
        int n;
        int mode;
        int sel;
        int extra;
        int unsigned pct;

        // Directed: empty table, extremes, start_new on a search, unsorted table,
        // duplicates and a single-element table.
        push_beat(KIND_SEARCH, 0, 1'b1, 0);
        push_beat(KIND_APPEND, 32'sh8000_0000, 1'b1, 0);
        push_beat(KIND_APPEND, 0, 1'b0, 0);
        push_beat(KIND_APPEND, 32'sh7fff_ffff, 1'b0, 0);
        push_beat(KIND_SEARCH, 32'sh8000_0000, 1'b0, 0);
        push_beat(KIND_SEARCH, 0, 1'b0, 0);
        push_beat(KIND_SEARCH, 32'sh7fff_ffff, 1'b0, 0);
        push_beat(KIND_SEARCH, 5, 1'b0, 0);
        push_beat(KIND_SEARCH, -1, 1'b0, 0);
        push_beat(KIND_SEARCH, 0, 1'b1, 0);
        push_beat(KIND_APPEND, 7, 1'b0, 0);
        push_beat(KIND_SEARCH, 7, 1'b0, 0);
        repeat (5) push_beat(KIND_APPEND, 5, gen_count == 5, 0);
        push_beat(KIND_SEARCH, 5, 1'b0, 0);
        push_beat(KIND_APPEND, 9, 1'b1, 0);
        push_beat(KIND_SEARCH, 9, 1'b0, 0);
        push_beat(KIND_SEARCH, 8, 1'b0, 0);
        push_beat(KIND_SEARCH, 10, 1'b0, 0);

        // Random: sorted tables, now and then with a stray element, followed by searches, with some growth and noise.
        while (random_total < RANDOM_BEATS)
        begin
            pct = phase_pct();
            sel = $urandom_range(0, 99);
            mode = $urandom_range(0, 2);
            n = (sel < 85) ? $urandom_range(1, 32) : $urandom_range(33, 200);
            build_table(n, mode, pct);
            push_searches($urandom_range(3, 12), mode, pct);
            random_total += n;
            if ($urandom_range(0, 9) < 3)
            begin
                extra = $urandom_range(1, 4);
                repeat (extra)
                    push_beat(KIND_APPEND, gen_table[gen_count - 1] + int'($urandom_range(0, 3)),
                              1'b0, pct);
                push_searches(4, mode, pct);
                random_total += extra + 4;
            end
            random_total += 8;
        end

        // Wait for every beat to be taken and every result to arrive.
        @(posedge rst_n);
        while (pending_beats.size() != 0 || expected_positions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("sorted_table_binary_search_unit_tb: done, clean");
        else
            $display("sorted_table_binary_search_unit_tb: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/stbs_pkg.sv
rtl/stbs_ram.sv
rtl/stbs_engine.sv
rtl/sorted_table_binary_search_unit.sv
sim/sorted_table_binary_search_unit_tb.sv
